// File: hw/rtl/sptd_pkg.sv
// Shared types, constants and helper functions for the sweep pulse timing decoder.
// Used by the top level, the frame buffer and the port checker; depends on nothing.
package sptd_pkg;

   localparam int SENSORS_DEFAULT   = 4;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int SENSOR_BITS    = 2;
   localparam int STAMP_BITS     = 32;
   localparam int REG_BITS       = 24;
   localparam int EDGE_BITS      = 8;
   localparam int CSR_INDEX_BITS = 4;

   localparam logic [REG_BITS-1:0] NOISE_RESET = 24'd2500;
   localparam logic [REG_BITS-1:0] SYNC_RESET  = 24'd190000;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NOISE_WIDTH = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYNC_WIDTH  = 4'd1;

   // Largest scaled sweep time: (2^24 - 1) * 3 / 5.
   localparam logic [REG_BITS-1:0] SCALED_MAX = 24'd10066329;

   // Multiply-by-reciprocal constants for the divide by five.
   localparam int                SCALE_SHIFT = 30;
   localparam logic [27:0]       SCALE_MUL   = 28'd214748365;

   typedef enum logic [2:0] {
      PH_WAIT_FIRST_SYNC = 3'd0,
      PH_WAIT_X_PULSE    = 3'd1,
      PH_WAIT_Y_SYNC     = 3'd2,
      PH_WAIT_Y_PULSE    = 3'd3,
      PH_WAIT_END_SYNC   = 3'd4,
      PH_WAIT_NEXT_SYNC  = 3'd5
   } phase_type;

   // One sensor's line of a frame.
   typedef struct packed {
      logic [REG_BITS-1:0]  x_scaled;
      logic [REG_BITS-1:0]  y_scaled;
      logic                 ready_res;
      logic [EDGE_BITS-1:0] extra_edges;
   } report_type;

   function automatic logic [REG_BITS-1:0] abs_diff(input logic [REG_BITS-1:0] a,
                                                     input logic [REG_BITS-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

   // Value times three fifths, truncated. The triple fits in 26 bits, well
   // inside the range where the rounded-up reciprocal gives the exact floor.
   function automatic logic [REG_BITS-1:0] scale_3_5(input logic [REG_BITS-1:0] v);
      logic [REG_BITS+1:0] triple;
      logic [55:0]         prod;
      triple    = {2'b00, v} + {1'b0, v, 1'b0};
      prod      = 56'(triple) * 56'(SCALE_MUL);
      scale_3_5 = REG_BITS'(prod >> SCALE_SHIFT);
   endfunction

endpackage

// File: hw/rtl/sptd_frame_buf.sv
// Frame buffer: holds a snapshot of every sensor's report and plays it out one beat per sensor.
// Depends on sptd_pkg for the report type and field widths.
module sptd_frame_buf
   import sptd_pkg::*;
#(
   parameter int SENSORS = SENSORS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  report_type             snapshot [SENSORS],
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SENSOR_BITS-1:0] rsp_sensor_out,
   output logic [REG_BITS-1:0]    rsp_x_scaled,
   output logic [REG_BITS-1:0]    rsp_y_scaled,
   output logic                   rsp_ready_res,
   output logic [EDGE_BITS-1:0]   rsp_extra_edges,
   output logic                   rsp_last
);

   localparam int IDX_BITS = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SENSORS - 1);

   report_type          frame_ff [SENSORS];
   logic [IDX_BITS-1:0] count_ff, count_in;
   logic                busy_ff, busy_in;
   logic                at_last;

   assign at_last = (count_ff == LAST_IDX);

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      if (load) begin
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff && rsp_ready) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= snapshot;
      end
   end

   assign free            = !busy_ff;
   assign rsp_valid       = busy_ff;
   assign rsp_sensor_out  = SENSOR_BITS'(count_ff);
   assign rsp_x_scaled    = frame_ff[count_ff].x_scaled;
   assign rsp_y_scaled    = frame_ff[count_ff].y_scaled;
   assign rsp_ready_res   = frame_ff[count_ff].ready_res;
   assign rsp_extra_edges = frame_ff[count_ff].extra_edges;
   assign rsp_last        = at_last;

endmodule

// File: hw/rtl/sweep_pulse_timing_decoder.sv
// Top level of the sweep pulse timing decoder: per-sensor sweep tracking and frame output.
// Depends on sptd_pkg and instantiates sptd_frame_buf.
//
// The decoder takes one falling-edge beat per cycle (sensor index and a
// free-running timestamp) into an input register, and settles that edge
// against its sensor's state from there. Edges closer than
// noise_width ticks to that sensor's last accepted edge are dropped; gaps
// wider than sync_width are sync flashes that restart the sensor at "wait
// for X pulse". Between syncs each sensor steps through X pulse, Y sync,
// Y pulse and end sync, and stray edges refine the stored sweep time when
// they lie closer to the previous frame's value. A sync edge that finds new
// data pending emits a frame of SENSORS result beats, sensors in order,
// each carrying the X and Y sweep times scaled by 3/5, the ready bit and
// the stray-edge count, with last set on the final beat. The frame shows
// the values from before the syncing edge's own update. Throughput is one
// input beat per cycle; the only stall is an edge that would start a frame
// while the previous frame still drains from the frame buffer. When the
// buffer is free, the edge that causes a frame goes from the input
// register straight into the frame buffer, which then presents the
// frame's first beat. The noise and sync widths are to be written through
// the csr port only while the block is idle; the block itself does not
// enforce this. Indexes other than the two registers are ignored. No
// clearing pass is needed after reset.
module sweep_pulse_timing_decoder
   import sptd_pkg::*;
#(
   parameter int SENSORS   = SENSORS_DEFAULT,
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SENSOR_BITS-1:0]    req_sensor,
   input  logic [STAMP_BITS-1:0]     req_timestamp,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SENSOR_BITS-1:0]    rsp_sensor_out,
   output logic [REG_BITS-1:0]       rsp_x_scaled,
   output logic [REG_BITS-1:0]       rsp_y_scaled,
   output logic                      rsp_ready_res,
   output logic [EDGE_BITS-1:0]      rsp_extra_edges,
   output logic                      rsp_last,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0]       csr_wdata
);

   localparam int IDX_BITS = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   // Interval compares run at the wider of the time and register widths.
   localparam int CMP_BITS = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;

   // Configuration registers.
   logic [REG_BITS-1:0] noise_ff;
   logic [REG_BITS-1:0] sync_ff;

   // Input register.
   logic                   in_valid_ff;
   logic [SENSOR_BITS-1:0] in_sensor_ff;
   logic [STAMP_BITS-1:0]  in_stamp_ff;

   // Per-sensor state, one flip-flop row per sensor.
   phase_type            phase_ff     [SENSORS];
   logic [TIME_BITS-1:0] last_edge_ff [SENSORS];
   logic [TIME_BITS-1:0] last_sync_ff [SENSORS];
   logic [REG_BITS-1:0]  sweep_x_ff   [SENSORS];
   logic [REG_BITS-1:0]  sweep_y_ff   [SENSORS];
   logic [REG_BITS-1:0]  prior_x_ff   [SENSORS];
   logic [REG_BITS-1:0]  prior_y_ff   [SENSORS];
   logic                 ready_ff     [SENSORS];
   logic [EDGE_BITS-1:0] edges_ff     [SENSORS];
   logic                 pending_ff;

   // Decode of the edge held in the input register.
   logic [IDX_BITS-1:0]  idx;
   logic                 sensor_ok;
   logic [TIME_BITS-1:0] stamp;
   logic [TIME_BITS-1:0] interval;
   logic [TIME_BITS-1:0] since_sync;
   logic                 is_noise, is_sync, late_sync;
   logic [REG_BITS-1:0]  interval_r, since_r;
   logic                 live, emit, fire, update;
   logic                 buf_free;

   // Next values of the addressed sensor's row.
   phase_type            phase_in;
   logic [TIME_BITS-1:0] last_sync_in;
   logic [REG_BITS-1:0]  sweep_x_in, sweep_y_in;
   logic [EDGE_BITS-1:0] edges_in;
   logic                 ready_set;
   logic                 pending_set;
   logic [EDGE_BITS-1:0] edges_bumped;

   report_type snapshot [SENSORS];

   // Configuration writes are registered; unknown indexes do nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= NOISE_RESET;
         sync_ff  <= SYNC_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NOISE_WIDTH: noise_ff <= csr_wdata;
            CSR_SYNC_WIDTH:  sync_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The input register takes a beat whenever it is empty or its edge
   // retires in this cycle, so edges stream at one per cycle while no frame start waits.
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sensor_ff <= req_sensor;
         in_stamp_ff  <= req_timestamp;
      end
   end

   // Intervals wrap modulo 2^TIME_BITS, so a plain subtract is enough.
   assign sensor_ok  = (32'(in_sensor_ff) < SENSORS);
   assign idx        = IDX_BITS'(in_sensor_ff);
   assign stamp      = TIME_BITS'(in_stamp_ff);
   assign interval   = stamp - last_edge_ff[idx];
   assign since_sync = stamp - last_sync_ff[idx];
   assign is_noise   = CMP_BITS'(interval) < CMP_BITS'(noise_ff);
   assign is_sync    = CMP_BITS'(interval) > CMP_BITS'(sync_ff);
   assign late_sync  = CMP_BITS'(since_sync) > CMP_BITS'(sync_ff);
   // Both are below 2^24 wherever they are stored.
   assign interval_r = REG_BITS'(interval);
   assign since_r    = REG_BITS'(since_sync);

   // An edge that would start a frame waits until the buffer has drained
   // the previous one; every other edge retires at once.
   assign live   = in_valid_ff && sensor_ok && !is_noise;
   assign emit   = live && is_sync && pending_ff;
   assign fire   = in_valid_ff && !(emit && !buf_free);
   assign update = fire && live;

   assign edges_bumped = (edges_ff[idx] == '1) ? edges_ff[idx] : edges_ff[idx] + 1'b1;

   // Phase walk of the addressed sensor.
   always_comb begin
      phase_in     = phase_ff[idx];
      if (is_sync) begin
         phase_in = PH_WAIT_X_PULSE;
      end else begin
         unique case (phase_ff[idx])
            PH_WAIT_X_PULSE:  phase_in = PH_WAIT_Y_SYNC;
            PH_WAIT_Y_SYNC:   if (late_sync) phase_in = PH_WAIT_Y_PULSE;
            PH_WAIT_Y_PULSE:  phase_in = PH_WAIT_END_SYNC;
            PH_WAIT_END_SYNC: if (late_sync) phase_in = PH_WAIT_NEXT_SYNC;
            default: ;
         endcase
      end
   end

   // Data written along with the phase step.
   always_comb begin
      last_sync_in = last_sync_ff[idx];
      sweep_x_in   = sweep_x_ff[idx];
      sweep_y_in   = sweep_y_ff[idx];
      edges_in     = edges_ff[idx];
      ready_set    = 1'b0;
      pending_set  = 1'b0;
      if (is_sync) begin
         last_sync_in = stamp;
         edges_in     = '0;
      end else begin
         unique case (phase_ff[idx])
            PH_WAIT_X_PULSE: begin
               sweep_x_in = interval_r;
            end
            PH_WAIT_Y_SYNC: begin
               if (late_sync) begin
                  last_sync_in = stamp;
               end else begin
                  // A stray edge: keep whichever time sits closer to last frame.
                  if (abs_diff(since_r, prior_x_ff[idx]) <
                      abs_diff(sweep_x_ff[idx], prior_x_ff[idx])) begin
                     sweep_x_in = since_r;
                  end
                  edges_in = edges_bumped;
               end
            end
            PH_WAIT_Y_PULSE: begin
               sweep_y_in  = interval_r;
               ready_set   = 1'b1;
               pending_set = 1'b1;
            end
            PH_WAIT_END_SYNC: begin
               if (late_sync) begin
                  last_sync_in = stamp;
               end else begin
                  if (abs_diff(since_r, prior_y_ff[idx]) <
                      abs_diff(sweep_y_ff[idx], prior_y_ff[idx])) begin
                     sweep_y_in = since_r;
                  end
                  edges_in = edges_bumped;
               end
            end
            default: ;
         endcase
      end
   end

   // Frame emission touches every row (ready clears, sweeps become the
   // prior values); the addressed row then takes its own update.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSORS; i++) begin
            phase_ff[i]     <= PH_WAIT_FIRST_SYNC;
            last_edge_ff[i] <= '0;
            last_sync_ff[i] <= '0;
            sweep_x_ff[i]   <= '0;
            sweep_y_ff[i]   <= '0;
            prior_x_ff[i]   <= '0;
            prior_y_ff[i]   <= '0;
            ready_ff[i]     <= 1'b0;
            edges_ff[i]     <= '0;
         end
         pending_ff <= 1'b0;
      end else if (update) begin
         if (emit) begin
            for (int i = 0; i < SENSORS; i++) begin
               ready_ff[i]   <= 1'b0;
               prior_x_ff[i] <= sweep_x_ff[i];
               prior_y_ff[i] <= sweep_y_ff[i];
            end
            pending_ff <= 1'b0;
         end else if (pending_set) begin
            pending_ff <= 1'b1;
         end
         if (ready_set) begin
            ready_ff[idx] <= 1'b1;
         end
         phase_ff[idx]     <= phase_in;
         last_edge_ff[idx] <= stamp;
         last_sync_ff[idx] <= last_sync_in;
         sweep_x_ff[idx]   <= sweep_x_in;
         sweep_y_ff[idx]   <= sweep_y_in;
         edges_ff[idx]     <= edges_in;
      end
   end

   // The frame reports the rows as they stand before the syncing edge.
   always_comb begin
      for (int i = 0; i < SENSORS; i++) begin
         snapshot[i].x_scaled    = scale_3_5(sweep_x_ff[i]);
         snapshot[i].y_scaled    = scale_3_5(sweep_y_ff[i]);
         snapshot[i].ready_res   = ready_ff[i];
         snapshot[i].extra_edges = edges_ff[i];
      end
   end

   sptd_frame_buf #(
      .SENSORS(SENSORS)
   ) u_frame_buf (
      .clock          (clock),
      .reset          (reset),
      .load           (update && emit),
      .snapshot       (snapshot),
      .free           (buf_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sensor_out (rsp_sensor_out),
      .rsp_x_scaled   (rsp_x_scaled),
      .rsp_y_scaled   (rsp_y_scaled),
      .rsp_ready_res  (rsp_ready_res),
      .rsp_extra_edges(rsp_extra_edges),
      .rsp_last       (rsp_last)
   );

endmodule

// File: hw/rtl/sptd_checker.sv
// Port-level checks for the sweep pulse timing decoder, bound to the top level.
// Depends on sptd_pkg for field widths and the scaled-value ceiling.
module sptd_checker
   import sptd_pkg::*;
#(
   parameter int SENSORS = SENSORS_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SENSOR_BITS-1:0] rsp_sensor_out,
   input logic [REG_BITS-1:0]    rsp_x_scaled,
   input logic [REG_BITS-1:0]    rsp_y_scaled,
   input logic                   rsp_last
);

   // A stalled beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sensor_out))
      else $error("result beat changed while stalled");

   // Inside a frame the next sensor follows at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && (rsp_sensor_out == SENSOR_BITS'($past(rsp_sensor_out) + 1'b1)))
      else $error("frame beat missing or out of order");

   // The final beat belongs to the highest sensor, and a gap follows it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_sensor_out == SENSOR_BITS'(SENSORS - 1))
      else $error("last flag on the wrong sensor");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("frame followed without a gap");

   // Scaled times never exceed three fifths of the register range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_x_scaled <= SCALED_MAX && rsp_y_scaled <= SCALED_MAX)
      else $error("scaled sweep time out of range");

endmodule

bind sweep_pulse_timing_decoder sptd_checker #(
   .SENSORS(SENSORS)
) u_sptd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_sensor_out(rsp_sensor_out),
   .rsp_x_scaled  (rsp_x_scaled),
   .rsp_y_scaled  (rsp_y_scaled),
   .rsp_last      (rsp_last)
);
